/* rtl/core/rhsv_pkg.sv */
// Package: pixel, result and pipeline stage types for the RGB to HSV converter.
package rhsv_pkg;

	localparam int PixelBits = 8;
	localparam int FracBits  = 16;
	localparam int HueBits   = PixelBits + 3;

	typedef struct packed {
		logic [PixelBits-1:0] red;
		logic [PixelBits-1:0] green;
		logic [PixelBits-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [FracBits-1:0]  hue;
		logic [FracBits-1:0]  saturation;
		logic [PixelBits-1:0] value_level;
	} hsv_t;

	// Partial state of both long divisions, handed from cell to cell.
	typedef struct packed {
		logic [HueBits-1:0]   rem_h;
		logic [HueBits-1:0]   div_h;
		logic [PixelBits-1:0] rem_s;
		logic [PixelBits-1:0] div_s;
		logic [FracBits-1:0]  num_s;
		logic [FracBits-1:0]  quo_h;
		logic [FracBits-1:0]  quo_s;
		logic [PixelBits-1:0] value;
	} stage_t;

endpackage

/* rtl/core/rhsv_front.sv */
// Front stage: max/min, chroma, hue sector offset and division setup.
module rhsv_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             up_valid,
	input  rhsv_pkg::pixel_t up_data,
	output logic             up_ready,
	output logic             dn_valid,
	output rhsv_pkg::stage_t dn_data,
	input  logic             dn_ready
);

	localparam int PB = rhsv_pkg::PixelBits;
	localparam int HB = rhsv_pkg::HueBits;
	localparam int FB = rhsv_pkg::FracBits;

	logic             is_r, is_g;
	logic [PB-1:0]    v, lo, c;
	logic [HB-1:0]    c6;
	logic [HB:0]      base, diff, t, tf;
	logic [PB+FB-1:0] num;
	rhsv_pkg::stage_t nxt;
	rhsv_pkg::stage_t data_s1;
	logic             valid_s1;

	always_comb begin
		is_r = (up_data.red >= up_data.green) && (up_data.red >= up_data.blue);
		is_g = !is_r && (up_data.green >= up_data.blue);
		if (is_r) begin
			v = up_data.red;
		end else if (is_g) begin
			v = up_data.green;
		end else begin
			v = up_data.blue;
		end
		lo = up_data.red;
		if (up_data.green < lo) begin
			lo = up_data.green;
		end
		if (up_data.blue < lo) begin
			lo = up_data.blue;
		end
		c  = v - lo;
		c6 = {1'b0, c, 2'b00} + {2'b00, c, 1'b0};
		if (is_r) begin
			base = '0;
			diff = {4'b0000, up_data.green} - {4'b0000, up_data.blue};
		end else if (is_g) begin
			base = {3'b000, c, 1'b0};
			diff = {4'b0000, up_data.blue} - {4'b0000, up_data.red};
		end else begin
			base = {2'b00, c, 2'b00};
			diff = {4'b0000, up_data.red} - {4'b0000, up_data.green};
		end
		t  = base + diff;
		tf = t[HB] ? (t + {1'b0, c6}) : t;
		num = {c, {FB{1'b0}}} - {{FB{1'b0}}, c};

		nxt.rem_h = tf[HB-1:0];
		// a grey pixel divides by all ones so the quotient comes out zero
		nxt.div_h = (c == '0) ? {HB{1'b1}} : c6;
		nxt.rem_s = num[PB+FB-1:FB];
		nxt.div_s = (v == '0) ? {PB{1'b1}} : v;
		nxt.num_s = num[FB-1:0];
		nxt.quo_h = '0;
		nxt.quo_s = '0;
		nxt.value = v;
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s1 <= nxt;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data  = data_s1;

endmodule

/* rtl/core/rhsv_cell.sv */
// Division cell: one quotient bit of hue and of saturation per stage.
module rhsv_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             up_valid,
	input  rhsv_pkg::stage_t up_data,
	output logic             up_ready,
	output logic             dn_valid,
	output rhsv_pkg::stage_t dn_data,
	input  logic             dn_ready
);

	localparam int PB = rhsv_pkg::PixelBits;
	localparam int HB = rhsv_pkg::HueBits;
	localparam int FB = rhsv_pkg::FracBits;

	logic [HB:0]      sh_h, df_h;
	logic [PB:0]      sh_s, df_s;
	logic             ge_h, ge_s;
	rhsv_pkg::stage_t nxt;
	rhsv_pkg::stage_t data_s1;
	logic             valid_s1;

	always_comb begin
		sh_h = {up_data.rem_h, 1'b0};
		df_h = sh_h - {1'b0, up_data.div_h};
		ge_h = sh_h >= {1'b0, up_data.div_h};
		sh_s = {up_data.rem_s, up_data.num_s[FB-1]};
		df_s = sh_s - {1'b0, up_data.div_s};
		ge_s = sh_s >= {1'b0, up_data.div_s};

		nxt       = up_data;
		nxt.rem_h = ge_h ? df_h[HB-1:0] : sh_h[HB-1:0];
		nxt.rem_s = ge_s ? df_s[PB-1:0] : sh_s[PB-1:0];
		nxt.num_s = {up_data.num_s[FB-2:0], 1'b0};
		nxt.quo_h = {up_data.quo_h[FB-2:0], ge_h};
		nxt.quo_s = {up_data.quo_s[FB-2:0], ge_s};
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s1 <= nxt;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data  = data_s1;

endmodule

/* rtl/core/rgb_to_hsv_pixel_unit.sv */
// Top level: RGB to HSV pixel converter, front stage followed by a row of division cells.
//
// Input channel pix/pix_valid/pix_stall carries one RGB pixel per transaction;
// output channel hsv/hsv_valid/hsv_stall carries hue (0.16 turn), saturation
// (65535 means one) and value. Every pixel gives exactly one result, in order.
// Throughput is one pixel per clock while hsv_stall is low. A pixel passes
// through 17 register stages on its way to hsv_valid: one front stage (max,
// min, chroma, hue offset) and one cell per quotient bit for the 16-bit hue
// and saturation long divisions.
// Each stage has its own valid bit and moves when the stage after it is empty
// or moving, so bubbles close up and pix_stall rises only when every stage
// holds a transaction and the receiver stalls. A stalled result holds in the
// last cell. Reset clears all valid bits; the pipeline is empty afterward and
// pix_stall is low, so it can accept a pixel.
module rgb_to_hsv_pixel_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pix_valid,
	output logic             pix_stall,
	input  rhsv_pkg::pixel_t pix,
	output logic             hsv_valid,
	input  logic             hsv_stall,
	output rhsv_pkg::hsv_t   hsv
);

	localparam int Cells = rhsv_pkg::FracBits;

	rhsv_pkg::stage_t chain_data [0:Cells];
	logic             chain_valid [0:Cells];
	logic             chain_ready [0:Cells+1];
	logic             front_ready;

	rhsv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (pix_valid),
		.up_data  (pix),
		.up_ready (front_ready),
		.dn_valid (chain_valid[0]),
		.dn_data  (chain_data[0]),
		.dn_ready (chain_ready[1])
	);

	for (genvar i = 1; i <= Cells; i++) begin : g_cell
		rhsv_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (chain_valid[i-1]),
			.up_data  (chain_data[i-1]),
			.up_ready (chain_ready[i]),
			.dn_valid (chain_valid[i]),
			.dn_data  (chain_data[i]),
			.dn_ready (chain_ready[i+1])
		);
	end

	assign chain_ready[0]       = front_ready;
	assign chain_ready[Cells+1] = !hsv_stall;
	assign pix_stall            = !chain_ready[0];

	assign hsv_valid       = chain_valid[Cells];
	assign hsv.hue         = chain_data[Cells].quo_h;
	assign hsv.saturation  = chain_data[Cells].quo_s;
	assign hsv.value_level = chain_data[Cells].value;

endmodule
